/* rtl/core/free_list_block_allocator_assert.svh */
// Assertion macros for the free-list block allocator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FLBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FLBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/flba_pkg.sv */
// Package for the free-list block allocator: pool sizing, field widths,
// operation codes and register indexes. No dependencies.
`default_nettype none

package flba_pkg;

    // Pool sizing; the null link is the value one past the last block
    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

    // Field widths
    localparam int FUNC_W = 2;
    localparam int BB_W   = 16;
    localparam int OFF_W  = 24;
    localparam int CNT_W  = LINK_W;
    localparam int CFG_W  = BB_W;
    localparam int CIDX_W = 2;

    // Smallest usable block: one link word
    localparam logic [BB_W-1:0] MIN_BLOCK_BYTES = BB_W'(8);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_BLOCK_BYTES   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

endpackage

`default_nettype wire

/* rtl/core/free_list_block_allocator.sv */
// When a beat is accepted the link memory is read at the head of the free list; the
// operation then commits (head, used count, link write for a free) and the result is
// loaded into the output register. If the output register is still held by a stalled
// result, the commit waits. No new beat is taken until the accepted one has committed.
// A pool reset clears a valid bit per link entry at once, and an entry that is not valid
// reads as the fresh chain value, so there is no clearing pass. blocks_in_use takes effect
// only at a pool reset operation or at block reset; block_bytes applies to the next result.
// Depends on flba_pkg and free_list_block_allocator_assert.svh.
`default_nettype none

`include "free_list_block_allocator_assert.svh"

module free_list_block_allocator
    import flba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [IDX_W-1:0]   free_index,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [IDX_W-1:0]        block_index,
    output logic [OFF_W-1:0]        byte_offset,
    output logic                    ok,
    output logic [CNT_W-1:0]        used_count,
    output logic [CNT_W-1:0]        available_count,
    output logic                    pool_full
);

    // Configuration registers
    logic [BB_W-1:0]        block_bytes_reg;
    logic [CNT_W-1:0]       blocks_in_use_reg;

    // Pool control state
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic                   exec_reg;
    logic [FUNC_W-1:0]      op_func_reg;
    logic [IDX_W-1:0]       op_fidx_reg;

    // Link memory, its read data and the per-entry valid bits
    logic [LINK_W-1:0]      link_mem [POOL_DEPTH];
    logic [LINK_W-1:0]      link_rd_reg;
    logic [POOL_DEPTH-1:0]  link_vld_reg;
    logic                   rd_vld_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       block_index_reg;
    logic [OFF_W-1:0]       byte_offset_reg;
    logic                   ok_reg;
    logic [CNT_W-1:0]       used_count_reg;
    logic [CNT_W-1:0]       available_count_reg;
    logic                   pool_full_reg;

    // Commit-cycle signals
    logic                   in_accept;
    logic                   commit;
    logic [CNT_W-1:0]       eff_cap;
    logic [BB_W-1:0]        bsize;
    logic [LINK_W:0]        head_plus1;
    logic [LINK_W-1:0]      chain_link;
    logic [LINK_W-1:0]      next_link;
    logic                   alloc_ok;
    logic                   free_ok;
    logic                   res_ok;
    logic [IDX_W-1:0]       res_idx;
    logic [OFF_W-1:0]       res_off;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = exec_reg;
    assign commit    = exec_reg && (!out_valid_reg || !out_stall);

    // Clamp the chained block count to 1..POOL_DEPTH
    always_comb
    begin
        eff_cap = blocks_in_use_reg;
        if (blocks_in_use_reg == '0)
            eff_cap = CNT_W'(1);
        else if (blocks_in_use_reg > CNT_W'(POOL_DEPTH))
            eff_cap = CNT_W'(POOL_DEPTH);
    end

    // Clamp block size to at least one link word
    assign bsize = (block_bytes_reg < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes_reg;

    // Link of the head: stored value if written since pool reset, else the fresh chain
    assign head_plus1 = {1'b0, head_reg} + (LINK_W+1)'(1);
    assign chain_link = (head_plus1 < {1'b0, cap_reg}) ? head_plus1[LINK_W-1:0] : LINK_NULL;
    assign next_link  = rd_vld_reg ? link_rd_reg : chain_link;

    // Operation checks
    assign alloc_ok = (op_func_reg == FUNC_ALLOC) && !head_reg[LINK_W-1]
                      && (head_reg < cap_reg) && (used_reg < cap_reg);
    assign free_ok  = (op_func_reg == FUNC_FREE) && (used_reg != '0)
                      && ({1'b0, op_fidx_reg} < cap_reg);

    // Next pool state and result
    always_comb
    begin
        head_next = head_reg;
        used_next = used_reg;
        cap_next  = cap_reg;
        res_ok    = 1'b0;
        res_idx   = '0;
        if (commit)
        begin
            unique case (op_func_reg)
                FUNC_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        head_next = next_link;
                        used_next = used_reg + CNT_W'(1);
                        res_ok    = 1'b1;
                        res_idx   = head_reg[IDX_W-1:0];
                    end
                end
                FUNC_FREE:
                begin
                    if (free_ok)
                    begin
                        head_next = {1'b0, op_fidx_reg};
                        used_next = used_reg - CNT_W'(1);
                        res_ok    = 1'b1;
                        res_idx   = op_fidx_reg;
                    end
                end
                FUNC_RESET:
                begin
                    head_next = '0;
                    used_next = '0;
                    cap_next  = eff_cap;
                    res_ok    = 1'b1;
                end
                FUNC_NOP:
                begin
                    res_ok = 1'b0;
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    assign res_off = OFF_W'(res_idx) * OFF_W'(bsize);

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg   <= MIN_BLOCK_BYTES;
            blocks_in_use_reg <= CNT_W'(POOL_DEPTH);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BLOCK_BYTES)
                block_bytes_reg <= cfg_data;
            else if (cfg_index == REG_BLOCKS_IN_USE)
                blocks_in_use_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            used_reg      <= '0;
            cap_reg       <= CNT_W'(POOL_DEPTH);
            exec_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            used_reg      <= used_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                exec_reg <= 1'b1;
            else if (commit)
                exec_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_func_reg <= func;
            op_fidx_reg <= free_index;
        end
    end

    // Link valid bits: clear on pool reset, set on every link write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_vld_reg <= '0;
        else if (commit && op_func_reg == FUNC_RESET)
            link_vld_reg <= '0;
        else if (commit && free_ok)
            link_vld_reg[op_fidx_reg] <= 1'b1;
    end

    // Link memory: read the head on accept, write the old head on a free commit
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
            rd_vld_reg  <= link_vld_reg[head_reg[IDX_W-1:0]];
        end
        if (commit && free_ok)
            link_mem[op_fidx_reg] <= head_reg;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            block_index_reg     <= res_idx;
            byte_offset_reg     <= res_off;
            ok_reg              <= res_ok;
            used_count_reg      <= used_next;
            available_count_reg <= cap_next - used_next;
            pool_full_reg       <= (used_next == cap_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign block_index     = block_index_reg;
    assign byte_offset     = byte_offset_reg;
    assign ok              = ok_reg;
    assign used_count      = used_count_reg;
    assign available_count = available_count_reg;
    assign pool_full       = pool_full_reg;

    // Checks
    `FLBA_ASSERT_IMP(a_used_le_cap, 1'b1, used_reg <= cap_reg,
        "used count exceeds active capacity")
    `FLBA_ASSERT_NXT(a_accept_exec, in_accept, exec_reg,
        "accepted beat did not enter the commit cycle")
    `FLBA_ASSERT_NXT(a_commit_out, commit, out_valid_reg && !exec_reg,
        "commit did not load the result register")
    `FLBA_ASSERT_IMP(a_cap_range, 1'b1, cap_reg != '0 && cap_reg <= CNT_W'(POOL_DEPTH),
        "active capacity out of range")

endmodule

`default_nettype wire

/* bench/free_list_tracker_pkg.sv */
// Scoreboard for the free-list block allocator bench: tracks the pool state
// beat by beat and holds the results still owed by the block. Depends on flba_pkg.
package free_list_tracker_pkg;

    import flba_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic [OFF_W-1:0] byte_offset;
        logic             ok;
        logic [CNT_W-1:0] used_count;
        logic [CNT_W-1:0] available_count;
        logic             pool_full;
    } pool_result_t;

    class free_list_tracker;
        logic [LINK_W-1:0] link_mem [POOL_DEPTH];
        logic [LINK_W-1:0] head;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  cap;
        logic [BB_W-1:0]   bytes_reg;
        logic [CNT_W-1:0]  blocks_reg;
        bit                held [POOL_DEPTH];
        pool_result_t      owed_results [$];
        int                errors;
        int                requests_seen;

        function new();
            bytes_reg     = BB_W'(8);
            blocks_reg    = CNT_W'(POOL_DEPTH);
            errors        = 0;
            requests_seen = 0;
            rebuild();
        endfunction

        // Latch the capacity and lay the chain 0 -> 1 -> ... -> cap-1
        function void rebuild();
            int unsigned c;
            c = blocks_reg;
            if (c == 0)
                c = 1;
            if (c > POOL_DEPTH)
                c = POOL_DEPTH;
            cap = CNT_W'(c);
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                link_mem[i] = (i + 1 < c) ? LINK_W'(i + 1) : LINK_NULL;
                held[i]     = 1'b0;
            end
            head = '0;
            used = '0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BLOCK_BYTES:   bytes_reg = data;
                REG_BLOCKS_IN_USE: blocks_reg = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Pick a random block that is handed out at the moment, -1 if none
        function int pick_held();
            int n;
            int k;
            n = 0;
            foreach (held[i])
                if (held[i])
                    n++;
            if (n == 0)
                return -1;
            k = $urandom_range(0, n - 1);
            foreach (held[i])
            begin
                if (held[i])
                begin
                    if (k == 0)
                        return i;
                    k--;
                end
            end
            return -1;
        endfunction

        // Apply one accepted request beat and queue the result it owes
        function void note_request(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] fi);
            pool_result_t r;
            int unsigned  bsize;
            int unsigned  idx;
            logic         good;
            bsize = (bytes_reg < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : bytes_reg;
            idx   = 0;
            good  = 1'b0;
            requests_seen++;
            case (f)
                FUNC_ALLOC:
                begin
                    if (head < POOL_DEPTH && head < cap && used < cap)
                    begin
                        idx       = head;
                        head      = link_mem[idx];
                        used      = used + 1'b1;
                        held[idx] = 1'b1;
                        good      = 1'b1;
                    end
                end
                FUNC_FREE:
                begin
                    if (used > 0 && fi < cap)
                    begin
                        link_mem[fi] = head;
                        head         = LINK_W'(fi);
                        used         = used - 1'b1;
                        held[fi]     = 1'b0;
                        idx          = fi;
                        good         = 1'b1;
                    end
                end
                FUNC_RESET:
                begin
                    rebuild();
                    good = 1'b1;
                end
                default: ;
            endcase
            r.block_index     = IDX_W'(idx);
            r.byte_offset     = OFF_W'(idx * bsize);
            r.ok              = good;
            r.used_count      = used;
            r.available_count = cap - used;
            r.pool_full       = (used == cap);
            owed_results.push_back(r);
        endfunction

        task report(string what);
            if (errors < 40)
                $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        // Compare one result beat against the oldest owed result
        task check_result(pool_result_t got);
            pool_result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result beat with nothing owed, index %0d", got.block_index));
                return;
            end
            want = owed_results.pop_front();
            if (got.block_index !== want.block_index)
                report($sformatf("block_index %0d, want %0d",
                                 got.block_index, want.block_index));
            if (got.byte_offset !== want.byte_offset)
                report($sformatf("byte_offset %0d, want %0d",
                                 got.byte_offset, want.byte_offset));
            if (got.ok !== want.ok)
                report($sformatf("ok %0b, want %0b", got.ok, want.ok));
            if (got.used_count !== want.used_count)
                report($sformatf("used_count %0d, want %0d",
                                 got.used_count, want.used_count));
            if (got.available_count !== want.available_count)
                report($sformatf("available_count %0d, want %0d",
                                 got.available_count, want.available_count));
            if (got.pool_full !== want.pool_full)
                report($sformatf("pool_full %0b, want %0b", got.pool_full, want.pool_full));
        endtask
    endclass

endpackage

/* bench/tb_top.sv */
// Bench top for the free-list block allocator: drives allocate, free, no-op and pool reset
// beats with random gaps and stalls, and checks every result against the tracker.
// Depends on flba_pkg, free_list_tracker_pkg and the allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import flba_pkg::*;
    import free_list_tracker_pkg::*;

    localparam logic [CIDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CIDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 8;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   free_index;
    logic               out_valid;
    logic               out_stall;
    logic [IDX_W-1:0]   block_index;
    logic [OFF_W-1:0]   byte_offset;
    logic               ok;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   available_count;
    logic               pool_full;

    free_list_tracker sb = new();
    pool_result_t     seen;
    bit               calm = 1'b0;
    bit               pressed = 1'b0;
    int               gap_pct = 0;
    int               idle_cycles = 0;

    free_list_block_allocator u_dut (.*);

    assign seen = '{block_index: block_index, byte_offset: byte_offset, ok: ok,
                    used_count: used_count, available_count: available_count,
                    pool_full: pool_full};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note accepted request beats and check accepted result beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(func, free_index);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(seen);
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold-off, none near the end
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressed && sb.requests_seen >= 450)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                pressed = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall = 1'b0;
            end
            else
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    // Offer one request beat, maybe after a gap, and hold it until accepted
    task automatic offer(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] fi);
        if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid   = 1'b1;
        func       = f;
        free_index = fi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        in_valid = 1'b0;
        while (sb.owed_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Configure, then run fill and drain segments with random content
    task automatic random_phase(input logic [CFG_W-1:0] bytes_val,
                                input logic [CFG_W-1:0] blocks_val,
                                input int n_items, input bit start_reset, input int gap);
        int                seg_left;
        int                roll;
        int                pick;
        int                reset_pct;
        bit                fill;
        logic [FUNC_W-1:0] f;
        logic [IDX_W-1:0]  fi;
        write_reg(REG_BLOCK_BYTES, bytes_val);
        write_reg(REG_BLOCKS_IN_USE, blocks_val);
        gap_pct  = gap;
        seg_left = 0;
        fill     = 1'b0;
        if (start_reset)
            offer(FUNC_RESET, IDX_W'($urandom));
        for (int k = 0; k < n_items; k++)
        begin
            if (seg_left == 0)
            begin
                fill     = !fill;
                seg_left = int'(sb.cap) * 3 / 2 + $urandom_range(4, 20);
            end
            seg_left--;
            reset_pct = (sb.cap > 64) ? 0 : 2;
            roll = $urandom_range(0, 99);
            fi   = IDX_W'($urandom);
            if (roll < reset_pct)
                f = FUNC_RESET;
            else if (roll < reset_pct + 3)
                f = FUNC_NOP;
            else if ($urandom_range(0, 99) < (fill ? 95 : 15))
                f = FUNC_ALLOC;
            else
            begin
                f    = FUNC_FREE;
                roll = $urandom_range(0, 99);
                pick = sb.pick_held();
                if (roll < 75 && pick >= 0)
                    fi = IDX_W'(pick);
                else if (roll < 90)
                    fi = IDX_W'($urandom_range(0, int'(sb.cap) - 1));
            end
            offer(f, fi);
        end
    endtask

    // Main sequence: reset, directed cases, random phases, drain and verdict
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = FUNC_NOP;
        free_index = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty free, allocs, no-op, frees at both index extremes
        gap_pct = 20;
        offer(FUNC_FREE, IDX_W'(0));
        offer(FUNC_ALLOC, IDX_W'(255));
        offer(FUNC_ALLOC, IDX_W'(0));
        offer(FUNC_NOP, IDX_W'(255));
        offer(FUNC_FREE, IDX_W'(255));
        offer(FUNC_FREE, IDX_W'(0));
        offer(FUNC_FREE, IDX_W'(1));

        // Largest block size; new capacity is not live until the pool reset
        write_reg(REG_BLOCK_BYTES, 16'hFFFF);
        write_reg(REG_BLOCKS_IN_USE, CFG_W'(2));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_RESET, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_FREE, IDX_W'(2));
        offer(FUNC_FREE, IDX_W'(1));
        offer(FUNC_FREE, IDX_W'(1));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_ALLOC, IDX_W'($urandom));
        offer(FUNC_FREE, IDX_W'(255));

        // Clamped block size and oversized capacity; unmapped registers do nothing
        write_reg(REG_BLOCK_BYTES, CFG_W'(3));
        write_reg(REG_BLOCKS_IN_USE, CFG_W'(300));
        write_reg(REG_UNMAPPED_2, 16'hFFFF);
        write_reg(REG_UNMAPPED_3, 16'h0000);
        offer(FUNC_RESET, IDX_W'(170));
        offer(FUNC_ALLOC, IDX_W'(85));
        offer(FUNC_FREE, IDX_W'(170));
        offer(FUNC_ALLOC, IDX_W'(0));
        offer(FUNC_FREE, IDX_W'(85));

        // Random phases across the register range, one full-depth fill among them
        random_phase(CFG_W'(8), CFG_W'(4), 120, 1'b1, 15);
        random_phase(16'hFFFF, CFG_W'(1), 80, 1'b1, 10);
        random_phase(CFG_W'(0), CFG_W'(0), 60, 1'b1, 25);
        random_phase(CFG_W'($urandom), CFG_W'(511), 650, 1'b1, 8);
        random_phase(CFG_W'(7), CFG_W'(17), 150, 1'b1, 0);
        random_phase(CFG_W'($urandom),
                     {7'($urandom), CNT_W'($urandom_range(2, 40))}, 150, 1'b0, 12);
        write_reg(REG_UNMAPPED_2, CFG_W'($urandom));
        random_phase(CFG_W'($urandom), CFG_W'(256), 200, 1'b1, 5);
        calm = 1'b1;
        random_phase(CFG_W'($urandom), CFG_W'(3), 150, 1'b1, 0);

        // Wait for every owed result, then a short tail
        in_valid = 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
